// File: rtl/householder_qr_macros.svh
// assertion macros for the householder qr block
// the including module provides clk and rst
`ifndef HOUSEHOLDER_QR_MACROS_SVH
`define HOUSEHOLDER_QR_MACROS_SVH

// same-cycle implication
`define HQR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HQR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hqr_pkg.sv
// shared types, constants and saturation helpers for the householder qr block
// no dependencies
package hqr_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_RESET   = 6;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE_A   = 3'd0,
    OP_WRITE_Q   = 3'd1,
    OP_DECOMPOSE = 3'd2,
    OP_READ_R    = 3'd3,
    OP_READ_Q    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_READ,
    TOP_DECOMP,
    TOP_FINISH
  } top_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_NORM,
    SQ_SQRT,
    SQ_DIAG,
    SQ_TAU,
    SQ_WVEC,
    SQ_SCALE,
    SQ_DOT,
    SQ_RUPD,
    SQ_QDOT,
    SQ_QUPD,
    SQ_NEXT,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic we;
    logic sel_q;
  } mem_ctl_t;

  typedef struct packed {
    logic done;
    logic degenerate;
    logic saturated;
  } seq_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = Q_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
  endfunction

endpackage

// File: rtl/hqr_sqrt.sv
// iterative floor square root of a 64-bit value, one result bit per cycle
// no package dependencies
module hqr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [4:0]  k;
  logic        busy;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign bitv  = 64'd1 << {k, 1'b0};
  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= x;
      res <= '0;
      k   <= 5'd31;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      k <= k - 5'd1;
    end
  end

endmodule

// File: rtl/hqr_div.sv
// iterative signed divider giving trunc(num * 2^16 / den), one bit per cycle
// no package dependencies
module hqr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic signed [63:0] quo,
  output logic               done
);

  logic [48:0] dvd;
  logic [31:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] nmag;
  logic [32:0] shifted;
  logic        fits;

  assign nmag    = num[32] ? 33'(-num) : 33'(num);
  assign shifted = {rem, dvd[48]};
  assign fits    = shifted >= {1'b0, dmag};
  assign quo     = neg ? -64'(dvd) : 64'(dvd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nmag, 16'd0};
      rem  <= '0;
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[32] ^ den[31];
      cnt  <= 6'd48;
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(shifted - {1'b0, dmag});
      end else begin
        rem <= shifted[31:0];
      end
      dvd <= {dvd[47:0], fits};
      cnt <= cnt - 6'd1;
    end
  end

endmodule

// File: rtl/hqr_seq.sv
// decomposition sequencer: walks the r and q memories column by column
// depends on hqr_pkg, hqr_sqrt, hqr_div
module hqr_seq #(
  parameter int MAX_DIM = hqr_pkg::MAX_DIM_DEF,
  localparam int CNT_W  = $clog2(MAX_DIM + 1),
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CNT_W-1:0]         rows_used,
  input  logic [CNT_W-1:0]         cols_used,
  input  logic signed [31:0]       r_rdata,
  input  logic signed [31:0]       q_rdata,
  output logic [ADDR_W-1:0]        addr,
  output logic signed [31:0]       wdata,
  output hqr_pkg::mem_ctl_t        mem_ctl,
  output hqr_pkg::seq_stat_t       stat
);

  localparam int ACC_W = 56;

  hqr_pkg::seq_state_t st, st_next;
  logic [1:0] ph, ph_next;

  logic [CNT_W-1:0] m, n, h, i, j;
  logic [63:0]        sum;
  logic signed [31:0] norm, u, tau, v, elem;
  logic               sgn_pos;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic               deg, satf;

  logic signed [31:0] w_vec  [MAX_DIM];
  logic signed [31:0] sw_vec [MAX_DIM];
  logic signed [31:0] p_vec  [MAX_DIM];

  logic [CNT_W:0] i_inc, j_inc, h_inc;
  logic i_last, j_last_n, j_last_m, h_last, i_done;
  logic [CNT_W-1:0] row, col, w_idx, sw_idx;
  logic signed [31:0] rd, w_rd, sw_rd, p_rd, mul_a, mul_b;
  logic signed [63:0] rnd;
  logic signed [47:0] mr;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [63:0] upd, uw;
  logic [64:0] sq_sum;

  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic               dv_start, dv_done;
  logic signed [32:0] dv_num;
  logic signed [31:0] dv_den;
  logic signed [63:0] dv_quo;

  hqr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sum),
    .root  (sq_root),
    .done  (sq_done)
  );

  hqr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .quo   (dv_quo),
    .done  (dv_done)
  );

  assign i_inc    = {1'b0, i} + 1'b1;
  assign j_inc    = {1'b0, j} + 1'b1;
  assign h_inc    = {1'b0, h} + 1'b1;
  assign i_last   = i_inc >= {1'b0, m};
  assign j_last_n = j_inc >= {1'b0, n};
  assign j_last_m = j_inc >= {1'b0, m};
  assign h_last   = h_inc >= {1'b0, n};
  assign i_done   = i >= m;

  assign w_idx  = (st == hqr_pkg::SQ_QDOT) ? j : i;
  assign sw_idx = (st == hqr_pkg::SQ_QUPD) ? j : i;
  assign w_rd   = w_vec[w_idx[IDX_W-1:0]];
  assign sw_rd  = sw_vec[sw_idx[IDX_W-1:0]];
  assign p_rd   = p_vec[j[IDX_W-1:0]];

  assign mem_ctl.sel_q = (st == hqr_pkg::SQ_QDOT) || (st == hqr_pkg::SQ_QUPD);
  assign mem_ctl.we    = (ph == 2'd2) &&
                         ((st == hqr_pkg::SQ_RUPD) || (st == hqr_pkg::SQ_QUPD));
  assign rd = mem_ctl.sel_q ? q_rdata : r_rdata;

  assign addr = ADDR_W'(int'(row[IDX_W-1:0]) * MAX_DIM + int'(col[IDX_W-1:0]));

  // rounded q16.16 product and its uses
  assign rnd     = prod + 64'sd32768;
  assign mr      = rnd[63:16];
  assign acc_sum = acc + ACC_W'(mr);
  assign upd     = 64'(elem) - 64'(mr);
  assign wdata   = hqr_pkg::sat32(upd);
  assign sq_sum  = {1'b0, sum} + {1'b0, prod};
  assign uw      = rd[31] ? (64'(rd) - 64'(norm)) : (64'(rd) + 64'(norm));

  assign stat.degenerate = deg;
  assign stat.saturated  = satf;

  always_comb begin
    row = i;
    col = j;
    mul_a = rd;
    mul_b = rd;
    case (st)
      hqr_pkg::SQ_NORM, hqr_pkg::SQ_WVEC: begin
        col = h;
      end
      hqr_pkg::SQ_DIAG: begin
        row = h;
        col = h;
      end
      hqr_pkg::SQ_SCALE: begin
        mul_a = w_rd;
        mul_b = tau;
      end
      hqr_pkg::SQ_DOT: begin
        mul_a = w_rd;
      end
      hqr_pkg::SQ_RUPD: begin
        mul_a = sw_rd;
        mul_b = p_rd;
      end
      hqr_pkg::SQ_QDOT: begin
        mul_b = w_rd;
      end
      hqr_pkg::SQ_QUPD: begin
        mul_a = v;
        mul_b = sw_rd;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_next   = st;
    ph_next   = ph;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    dv_num    = sgn_pos ? -33'(u) : 33'(u);
    dv_den    = norm;
    stat.done = 1'b0;
    case (st)
      hqr_pkg::SQ_IDLE: begin
        if (start) begin
          st_next = hqr_pkg::SQ_NORM;
          ph_next = 2'd0;
        end
      end
      hqr_pkg::SQ_NORM: begin
        ph_next = ph + 2'd1;
        if (ph == 2'd2) begin
          ph_next = 2'd0;
          if (i_last) st_next = hqr_pkg::SQ_SQRT;
        end
      end
      hqr_pkg::SQ_SQRT: begin
        if (ph == 2'd0) begin
          sq_start = 1'b1;
          ph_next  = 2'd1;
        end else if (sq_done) begin
          ph_next = 2'd0;
          st_next = (sq_root == '0) ? hqr_pkg::SQ_NEXT : hqr_pkg::SQ_DIAG;
        end
      end
      hqr_pkg::SQ_DIAG: begin
        if (ph == 2'd0) begin
          ph_next = 2'd1;
        end else begin
          ph_next = 2'd0;
          st_next = hqr_pkg::SQ_TAU;
        end
      end
      hqr_pkg::SQ_TAU: begin
        if (ph == 2'd0) begin
          dv_start = 1'b1;
          ph_next  = 2'd1;
        end else if (dv_done) begin
          ph_next = 2'd0;
          st_next = hqr_pkg::SQ_WVEC;
        end
      end
      hqr_pkg::SQ_WVEC: begin
        dv_num = 33'(rd);
        dv_den = u;
        case (ph)
          2'd0: begin
            if (i_done) st_next = hqr_pkg::SQ_SCALE;
            else ph_next = 2'd1;
          end
          2'd1: begin
            dv_start = 1'b1;
            ph_next  = 2'd2;
          end
          default: begin
            if (dv_done) ph_next = 2'd0;
          end
        endcase
      end
      hqr_pkg::SQ_SCALE: begin
        if (ph == 2'd0) begin
          ph_next = 2'd1;
        end else begin
          ph_next = 2'd0;
          if (i_last) st_next = hqr_pkg::SQ_DOT;
        end
      end
      hqr_pkg::SQ_DOT: begin
        ph_next = ph + 2'd1;
        if (ph == 2'd2) begin
          ph_next = 2'd0;
          if (i_last && j_last_n) st_next = hqr_pkg::SQ_RUPD;
        end
      end
      hqr_pkg::SQ_RUPD: begin
        ph_next = ph + 2'd1;
        if (ph == 2'd2) begin
          ph_next = 2'd0;
          if (i_last && j_last_n) st_next = hqr_pkg::SQ_QDOT;
        end
      end
      hqr_pkg::SQ_QDOT: begin
        ph_next = ph + 2'd1;
        if (ph == 2'd2) begin
          ph_next = 2'd0;
          if (j_last_m) st_next = hqr_pkg::SQ_QUPD;
        end
      end
      hqr_pkg::SQ_QUPD: begin
        ph_next = ph + 2'd1;
        if (ph == 2'd2) begin
          ph_next = 2'd0;
          if (j_last_m) begin
            st_next = i_last ? hqr_pkg::SQ_NEXT : hqr_pkg::SQ_QDOT;
          end
        end
      end
      hqr_pkg::SQ_NEXT: begin
        ph_next = 2'd0;
        st_next = h_last ? hqr_pkg::SQ_DONE : hqr_pkg::SQ_NORM;
      end
      hqr_pkg::SQ_DONE: begin
        stat.done = 1'b1;
        st_next   = hqr_pkg::SQ_IDLE;
      end
      default: begin
        st_next = hqr_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hqr_pkg::SQ_IDLE;
      ph <= 2'd0;
    end else begin
      st <= st_next;
      ph <= ph_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    elem <= rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg  <= 1'b0;
      satf <= 1'b0;
    end else begin
      case (st)
        hqr_pkg::SQ_IDLE: begin
          if (start) begin
            m    <= rows_used;
            n    <= (cols_used < rows_used) ? cols_used : rows_used;
            h    <= '0;
            i    <= '0;
            sum  <= '0;
            deg  <= 1'b0;
            satf <= 1'b0;
          end
        end
        hqr_pkg::SQ_NORM: begin
          if (ph == 2'd2) begin
            if (sq_sum[64]) begin
              sum  <= '1;
              satf <= 1'b1;
            end else begin
              sum <= sq_sum[63:0];
            end
            if (!i_last) i <= i_inc[CNT_W-1:0];
          end
        end
        hqr_pkg::SQ_SQRT: begin
          if (ph == 2'd1 && sq_done) begin
            if (sq_root[31]) begin
              norm <= hqr_pkg::Q_MAX;
              satf <= 1'b1;
            end else begin
              norm <= signed'(sq_root);
            end
            if (sq_root == '0) deg <= 1'b1;
          end
        end
        hqr_pkg::SQ_DIAG: begin
          if (ph == 2'd1) begin
            u       <= hqr_pkg::sat32(uw);
            sgn_pos <= rd[31];
            if (hqr_pkg::ovf32(uw)) satf <= 1'b1;
          end
        end
        hqr_pkg::SQ_TAU: begin
          if (ph == 2'd1 && dv_done) begin
            tau <= hqr_pkg::sat32(dv_quo);
            if (hqr_pkg::ovf32(dv_quo)) satf <= 1'b1;
            w_vec[h[IDX_W-1:0]] <= hqr_pkg::ONE_Q16;
            i <= h_inc[CNT_W-1:0];
          end
        end
        hqr_pkg::SQ_WVEC: begin
          if (ph == 2'd0 && i_done) begin
            i <= h;
          end else if (ph == 2'd2 && dv_done) begin
            w_vec[i[IDX_W-1:0]] <= hqr_pkg::sat32(dv_quo);
            if (hqr_pkg::ovf32(dv_quo)) satf <= 1'b1;
            i <= i_inc[CNT_W-1:0];
          end
        end
        hqr_pkg::SQ_SCALE: begin
          if (ph == 2'd1) begin
            sw_vec[i[IDX_W-1:0]] <= hqr_pkg::sat32(64'(mr));
            if (hqr_pkg::ovf32(64'(mr))) satf <= 1'b1;
            if (i_last) begin
              i   <= h;
              j   <= '0;
              acc <= '0;
            end else begin
              i <= i_inc[CNT_W-1:0];
            end
          end
        end
        hqr_pkg::SQ_DOT: begin
          if (ph == 2'd2) begin
            if (i_last) begin
              p_vec[j[IDX_W-1:0]] <= hqr_pkg::sat32(64'(acc_sum));
              if (hqr_pkg::ovf32(64'(acc_sum))) satf <= 1'b1;
              acc <= '0;
              i   <= h;
              j   <= j_last_n ? '0 : j_inc[CNT_W-1:0];
            end else begin
              acc <= acc_sum;
              i   <= i_inc[CNT_W-1:0];
            end
          end
        end
        hqr_pkg::SQ_RUPD: begin
          if (ph == 2'd2) begin
            if (hqr_pkg::ovf32(upd)) satf <= 1'b1;
            if (j_last_n) begin
              if (i_last) begin
                i   <= '0;
                j   <= h;
                acc <= '0;
              end else begin
                i <= i_inc[CNT_W-1:0];
                j <= '0;
              end
            end else begin
              j <= j_inc[CNT_W-1:0];
            end
          end
        end
        hqr_pkg::SQ_QDOT: begin
          if (ph == 2'd2) begin
            if (j_last_m) begin
              v   <= hqr_pkg::sat32(64'(acc_sum));
              if (hqr_pkg::ovf32(64'(acc_sum))) satf <= 1'b1;
              acc <= '0;
              j   <= h;
            end else begin
              acc <= acc_sum;
              j   <= j_inc[CNT_W-1:0];
            end
          end
        end
        hqr_pkg::SQ_QUPD: begin
          if (ph == 2'd2) begin
            if (hqr_pkg::ovf32(upd)) satf <= 1'b1;
            if (j_last_m) begin
              j <= h;
              if (!i_last) i <= i_inc[CNT_W-1:0];
            end else begin
              j <= j_inc[CNT_W-1:0];
            end
          end
        end
        hqr_pkg::SQ_NEXT: begin
          h   <= h_inc[CNT_W-1:0];
          i   <= h_inc[CNT_W-1:0];
          sum <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/householder_qr.sv
// householder_qr: an element write is stored at its transfer; a read is registered from memory,
// then loaded into the result register once the output is free; decompose runs per column h with
// k = m - h rows using the shared multiplier and the one-bit-per-cycle square root and divide
// units (a zero-norm column is skipped after its root), then loads its flags; other requests wait
// reset clears control, flags and the dimension registers (both 6, or MAX_DIM if smaller);
// the r and q memories are not cleared and hold their contents until written
module householder_qr #(
  parameter int MAX_DIM = hqr_pkg::MAX_DIM_DEF,
  localparam int CNT_W  = $clog2(MAX_DIM + 1),
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic               degenerate,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata
);

`include "householder_qr_macros.svh"

  localparam int RESET_DIM = (hqr_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : hqr_pkg::DIM_RESET;

  hqr_pkg::top_state_t state, state_next;
  hqr_pkg::mem_ctl_t   mem_ctl;
  hqr_pkg::seq_stat_t  stat;

  logic [CNT_W-1:0] rows_used, cols_used;
  logic [CNT_W-1:0] cfg_dim;

  logic signed [31:0] r_mem [MAX_DIM * MAX_DIM];
  logic signed [31:0] q_mem [MAX_DIM * MAX_DIM];
  logic signed [31:0] r_rdata, q_rdata;

  logic               r_we, q_we, r_re, q_re;
  logic [ADDR_W-1:0]  mem_addr, host_addr, seq_addr;
  logic signed [31:0] mem_wdata, seq_wdata;

  logic accept, in_range, dec, seq_start, out_free, out_load;
  logic rd_q, rd_inside;
  logic signed [31:0] load_value;

  assign in_ready = (state == hqr_pkg::TOP_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign host_addr = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
  assign dec      = (state == hqr_pkg::TOP_DECOMP);
  assign out_free = !out_valid || out_ready;
  assign seq_start = accept && (opcode == hqr_pkg::OP_DECOMPOSE);

  hqr_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (seq_start),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .r_rdata   (r_rdata),
    .q_rdata   (q_rdata),
    .addr      (seq_addr),
    .wdata     (seq_wdata),
    .mem_ctl   (mem_ctl),
    .stat      (stat)
  );

  // memory port sharing between host transfers and the sequencer
  always_comb begin
    if (dec) begin
      r_we      = mem_ctl.we && !mem_ctl.sel_q;
      q_we      = mem_ctl.we && mem_ctl.sel_q;
      r_re      = 1'b1;
      q_re      = 1'b1;
      mem_addr  = seq_addr;
      mem_wdata = seq_wdata;
    end else begin
      r_we      = accept && in_range && (opcode == hqr_pkg::OP_WRITE_A);
      q_we      = accept && in_range && (opcode == hqr_pkg::OP_WRITE_Q);
      r_re      = accept && (opcode == hqr_pkg::OP_READ_R);
      q_re      = accept && (opcode == hqr_pkg::OP_READ_Q);
      mem_addr  = host_addr;
      mem_wdata = write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[mem_addr] <= mem_wdata;
    end else if (r_re) begin
      r_rdata <= r_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[mem_addr] <= mem_wdata;
    end else if (q_re) begin
      q_rdata <= q_mem[mem_addr];
    end
  end

  // dimension registers, clamped to 1..MAX_DIM
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_dim = CNT_W'(1);
    end else if (int'(cfg_wdata) > MAX_DIM) begin
      cfg_dim = CNT_W'(MAX_DIM);
    end else begin
      cfg_dim = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= CNT_W'(RESET_DIM);
      cols_used <= CNT_W'(RESET_DIM);
    end else if (cfg_we) begin
      if (cfg_index == hqr_pkg::CFG_ROWS) rows_used <= cfg_dim;
      if (cfg_index == hqr_pkg::CFG_COLS) cols_used <= cfg_dim;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q      <= (opcode == hqr_pkg::OP_READ_Q);
      rd_inside <= in_range;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    load_value = '0;
    case (state)
      hqr_pkg::TOP_IDLE: begin
        if (accept) begin
          if (opcode == hqr_pkg::OP_READ_R || opcode == hqr_pkg::OP_READ_Q) begin
            state_next = hqr_pkg::TOP_READ;
          end else if (opcode == hqr_pkg::OP_DECOMPOSE) begin
            state_next = hqr_pkg::TOP_DECOMP;
          end
        end
      end
      hqr_pkg::TOP_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_value = rd_inside ? (rd_q ? q_rdata : r_rdata) : '0;
          state_next = hqr_pkg::TOP_IDLE;
        end
      end
      hqr_pkg::TOP_DECOMP: begin
        if (stat.done) state_next = hqr_pkg::TOP_FINISH;
      end
      hqr_pkg::TOP_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = hqr_pkg::TOP_IDLE;
        end
      end
      default: begin
        state_next = hqr_pkg::TOP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hqr_pkg::TOP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded when a transfer frees it
  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value <= load_value;
      degenerate <= stat.degenerate;
      saturated  <= stat.saturated;
    end
  end

  `HQR_ASSERT(a_done_in_decomp, stat.done, state == hqr_pkg::TOP_DECOMP, "sequencer done outside decompose")
  `HQR_ASSERT_NEXT(a_decomp_enters, seq_start, state == hqr_pkg::TOP_DECOMP, "decompose not entered")
  `HQR_ASSERT(a_one_writer, r_we || q_we, !(r_we && q_we), "both memories written at once")
  `HQR_ASSERT(a_no_host_write, dec && (r_we || q_we), mem_ctl.we, "host write during decompose")

endmodule
